### hdl/svc_pkg.sv
// Shared constants for the segment viewport cull unit.
package svc_pkg;

  // Clearance field width and pen width result
  localparam int unsigned CLEAR_BITS = 28;
  localparam int unsigned PEN_BITS   = 32;

  // Result word: visible, stroke, pen_width, padded to whole bytes
  localparam int unsigned OUT_BITS = ((2 + PEN_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_LEFT   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_BOTTOM = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_RIGHT  = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VIEW_TOP    = 2'd3;

endpackage

### hdl/segment_viewport_cull_unit.sv
// Segment viewport cull unit: seven-stage pipeline deciding segment visibility.
//
// Usage: segments arrive on the s_axis channel, one word per segment; tdata
// carries start_x, start_y, end_x, end_y, line_width and clearance, tuser the
// draw mode. Each segment yields one result word on m_axis: visible, stroke
// and pen_width. The viewport is set through the cfg write port (index 0
// left, 1 bottom, 2 right, 3 top) while no segment is in flight.
// Throughput is one segment per cycle while m_axis_tready stays high.
// The pipeline registers, in order, the margin, grown viewport, corner
// offsets, split products, product sum and cross-product sign, each in a
// register stage of its own, then the result word in the output register.
// Every stage has its own valid bit and advances when the next stage is
// empty or advancing, so bubbles close up and a stalled receiver only holds
// back the stages behind a full output register; no word is lost or repeated.
// Reset clears all valid bits and the viewport registers to zero; the unit
// is ready for a segment in the first cycle after reset.
module segment_viewport_cull_unit #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [svc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [COORD_BITS-1:0]               cfg_wdata_i,
  // Segment input channel
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, lowest bit up: start_x, start_y, end_x, end_y, line_width, clearance
  input  logic [((5*COORD_BITS+svc_pkg::CLEAR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: draw_mode
  input  logic                                s_axis_tuser,
  // Result channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, lowest bit up: visible, stroke, pen_width
  output logic [svc_pkg::OUT_BITS-1:0]        m_axis_tdata
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned CB  = svc_pkg::CLEAR_BITS;
  localparam int unsigned PB  = svc_pkg::PEN_BITS;
  localparam int unsigned DW  = C + 1;                      // endpoint difference
  localparam int unsigned MW  = ((C > CB + 1) ? C : CB + 1) + 1; // margin
  localparam int unsigned GW  = MW + 1;                     // grown viewport bound
  localparam int unsigned BW  = GW + 1;                     // corner offset
  localparam int unsigned LO  = BW / 2;                     // low slice of offset
  localparam int unsigned HI  = BW - LO;                    // high slice of offset
  localparam int unsigned PLW = DW + LO + 1;                // low partial product
  localparam int unsigned PHW = DW + HI;                    // high partial product
  localparam int unsigned PW  = DW + BW;                    // full product
  localparam int unsigned NST = 7;                          // pipeline stages

  // Viewport registers
  logic signed [C-1:0] view_left_q, view_bottom_q, view_right_q, view_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_left_q   <= '0;
      view_bottom_q <= '0;
      view_right_q  <= '0;
      view_top_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        svc_pkg::REG_VIEW_LEFT:   view_left_q   <= cfg_wdata_i;
        svc_pkg::REG_VIEW_BOTTOM: view_bottom_q <= cfg_wdata_i;
        svc_pkg::REG_VIEW_RIGHT:  view_right_q  <= cfg_wdata_i;
        svc_pkg::REG_VIEW_TOP:    view_top_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage loads when it is empty or its successor loads
  logic [NST:1]   vld_q;
  logic [NST+1:1] en;
  logic [NST-1:0] vld_in;

  always_comb begin
    en[NST+1] = m_axis_tready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_in = {vld_q[NST-1:1], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) vld_q[k] <= vld_in[k-1];
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld_q[NST];

  // Input word fields
  logic signed [C-1:0]  in_xi, in_yi, in_xf, in_yf, in_w;
  logic        [CB-1:0] in_clr;

  assign in_xi  = s_axis_tdata[C-1:0];
  assign in_yi  = s_axis_tdata[2*C-1:C];
  assign in_xf  = s_axis_tdata[3*C-1:2*C];
  assign in_yf  = s_axis_tdata[4*C-1:3*C];
  assign in_w   = s_axis_tdata[5*C-1:4*C];
  assign in_clr = s_axis_tdata[5*C+CB-1:5*C];

  // Stage 1: margin, bounding box, direction, pen width
  logic signed [C-1:0]  half_w;
  logic signed [MW-1:0] s1_margin_d, s1_margin_q;
  logic signed [C-1:0]  s1_minx_q, s1_maxx_q, s1_miny_q, s1_maxy_q, s1_xi_q, s1_yi_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic                 s1_obl_q, s1_supp_q;
  logic        [PB-1:0] s1_pen_d, s1_pen_q;

  always_comb begin
    // halve with truncation toward zero
    half_w = (in_w >>> 1) + $signed({{(C-1){1'b0}}, in_w[C-1] & in_w[0]});
    s1_margin_d = MW'(half_w) + $signed(MW'(in_clr));
    s1_pen_d = s_axis_tuser ? PB'(in_w) : PB'(in_w) + PB'({in_clr, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_margin_q <= s1_margin_d;
      s1_minx_q   <= (in_xi < in_xf) ? in_xi : in_xf;
      s1_maxx_q   <= (in_xi < in_xf) ? in_xf : in_xi;
      s1_miny_q   <= (in_yi < in_yf) ? in_yi : in_yf;
      s1_maxy_q   <= (in_yi < in_yf) ? in_yf : in_yi;
      s1_xi_q     <= in_xi;
      s1_yi_q     <= in_yi;
      s1_dx_q     <= DW'(in_xf) - DW'(in_xi);
      s1_dy_q     <= DW'(in_yf) - DW'(in_yi);
      s1_obl_q    <= (in_xi != in_xf) && (in_yi != in_yf);
      s1_supp_q   <= s_axis_tuser & in_w[C-1];
      s1_pen_q    <= s1_pen_d;
    end
  end

  // Stage 2: grow the viewport by the margin
  logic signed [GW-1:0] s2_xl_q, s2_xr_q, s2_yb_q, s2_yt_q;
  logic signed [C-1:0]  s2_minx_q, s2_maxx_q, s2_miny_q, s2_maxy_q, s2_xi_q, s2_yi_q;
  logic signed [DW-1:0] s2_dx_q, s2_dy_q;
  logic                 s2_obl_q, s2_supp_q;
  logic        [PB-1:0] s2_pen_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_xl_q   <= GW'(view_left_q)   - GW'(s1_margin_q);
      s2_xr_q   <= GW'(view_right_q)  + GW'(s1_margin_q);
      s2_yb_q   <= GW'(view_bottom_q) - GW'(s1_margin_q);
      s2_yt_q   <= GW'(view_top_q)    + GW'(s1_margin_q);
      s2_minx_q <= s1_minx_q;
      s2_maxx_q <= s1_maxx_q;
      s2_miny_q <= s1_miny_q;
      s2_maxy_q <= s1_maxy_q;
      s2_xi_q   <= s1_xi_q;
      s2_yi_q   <= s1_yi_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_obl_q  <= s1_obl_q;
      s2_supp_q <= s1_supp_q;
      s2_pen_q  <= s1_pen_q;
    end
  end

  // Stage 3: bounding box overlap and corner offsets from the start point
  // lanes 0,1 multiply dx by the bottom/top offsets, lanes 2,3 dy by left/right
  logic signed [DW-1:0] s3_a_q [4];
  logic signed [BW-1:0] s3_b_q [4];
  logic                 s3_box_q, s3_obl_q, s3_supp_q;
  logic        [PB-1:0] s3_pen_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_box_q  <= (GW'(s2_maxx_q) >= s2_xl_q) && (GW'(s2_minx_q) <= s2_xr_q) &&
                   (GW'(s2_maxy_q) >= s2_yb_q) && (GW'(s2_miny_q) <= s2_yt_q);
      s3_a_q[0] <= s2_dx_q;
      s3_a_q[1] <= s2_dx_q;
      s3_a_q[2] <= s2_dy_q;
      s3_a_q[3] <= s2_dy_q;
      s3_b_q[0] <= BW'(s2_yb_q) - BW'(s2_yi_q);
      s3_b_q[1] <= BW'(s2_yt_q) - BW'(s2_yi_q);
      s3_b_q[2] <= BW'(s2_xl_q) - BW'(s2_xi_q);
      s3_b_q[3] <= BW'(s2_xr_q) - BW'(s2_xi_q);
      s3_obl_q  <= s2_obl_q;
      s3_supp_q <= s2_supp_q;
      s3_pen_q  <= s2_pen_q;
    end
  end

  // Stage 4: partial products on the low and high slices of each offset
  logic signed [PLW-1:0] s4_lo_q [4];
  logic signed [PHW-1:0] s4_hi_q [4];
  logic                  s4_box_q, s4_obl_q, s4_supp_q;
  logic         [PB-1:0] s4_pen_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        s4_lo_q[k] <= PLW'(s3_a_q[k]) * PLW'($signed({1'b0, s3_b_q[k][LO-1:0]}));
        s4_hi_q[k] <= PHW'(s3_a_q[k]) * PHW'($signed(s3_b_q[k][BW-1:LO]));
      end
      s4_box_q  <= s3_box_q;
      s4_obl_q  <= s3_obl_q;
      s4_supp_q <= s3_supp_q;
      s4_pen_q  <= s3_pen_q;
    end
  end

  // Stage 5: assemble full products
  logic signed [PW-1:0] s5_p_q [4];
  logic                 s5_box_q, s5_obl_q, s5_supp_q;
  logic        [PB-1:0] s5_pen_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < 4; k++) begin
        s5_p_q[k] <= (PW'(s4_hi_q[k]) <<< LO) + PW'(s4_lo_q[k]);
      end
      s5_box_q  <= s4_box_q;
      s5_obl_q  <= s4_obl_q;
      s5_supp_q <= s4_supp_q;
      s5_pen_q  <= s4_pen_q;
    end
  end

  // Stage 6: cross product sign at each grown corner
  // corners: left-bottom, right-bottom, left-top, right-top
  logic signed [PW:0] cross_prod [4];
  logic        [3:0]  s6_pos_q, s6_neg_q;
  logic               s6_box_q, s6_obl_q, s6_supp_q;
  logic      [PB-1:0] s6_pen_q;

  always_comb begin
    cross_prod[0] = (PW+1)'(s5_p_q[0]) - (PW+1)'(s5_p_q[2]);
    cross_prod[1] = (PW+1)'(s5_p_q[0]) - (PW+1)'(s5_p_q[3]);
    cross_prod[2] = (PW+1)'(s5_p_q[1]) - (PW+1)'(s5_p_q[2]);
    cross_prod[3] = (PW+1)'(s5_p_q[1]) - (PW+1)'(s5_p_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        s6_neg_q[k] <= cross_prod[k][PW];
        s6_pos_q[k] <= ~cross_prod[k][PW] & (|cross_prod[k]);
      end
      s6_box_q  <= s5_box_q;
      s6_obl_q  <= s5_obl_q;
      s6_supp_q <= s5_supp_q;
      s6_pen_q  <= s5_pen_q;
    end
  end

  // Stage 7: output register
  logic          s7_vis_d, s7_vis_q, s7_stroke_q;
  logic [PB-1:0] s7_pen_q;

  // an oblique line with all corners strictly on one side misses the viewport
  assign s7_vis_d = s6_box_q & ~(s6_obl_q & ((&s6_pos_q) | (&s6_neg_q)));

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_vis_q    <= s7_vis_d;
      s7_stroke_q <= s7_vis_d & ~s6_supp_q;
      s7_pen_q    <= s6_pen_q;
    end
  end

  assign m_axis_tdata = {{(svc_pkg::OUT_BITS-PB-2){1'b0}}, s7_pen_q, s7_stroke_q, s7_vis_q};

endmodule

### tb/segment_viewport_cull_unit_tb.sv
// Self-checking testbench for the segment viewport cull unit.
module segment_viewport_cull_unit_tb;

  localparam int unsigned COORD_BITS   = 31;
  localparam int unsigned CLR_BITS     = svc_pkg::CLEAR_BITS;
  localparam int unsigned PEN_W        = svc_pkg::PEN_BITS;
  localparam int unsigned IN_BITS      = ((5 * COORD_BITS + CLR_BITS + 7) / 8) * 8;
  localparam longint      COORD_MIN    = -(longint'(1) <<< (COORD_BITS - 1));
  localparam longint      COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint      CLR_MAX      = (longint'(1) <<< CLR_BITS) - 1;
  localparam int unsigned MAX_IDLE     = 11;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam longint      NEAR_PAD     = 3000;

  // One segment word as the predictor sees it
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] line_width;
    logic [CLR_BITS-1:0]          clearance;
    logic                         draw_mode;
  } segment_t;

  typedef struct packed {
    logic             visible;
    logic             stroke;
    logic [PEN_W-1:0] pen_width;
  } cull_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [svc_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [COORD_BITS-1:0]            cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  // tdata, lowest bit up: start_x, start_y, end_x, end_y, line_width, clearance
  logic [IN_BITS-1:0]               s_axis_tdata;
  // tuser: draw_mode
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // tdata, lowest bit up: visible, stroke, pen_width
  logic [svc_pkg::OUT_BITS-1:0]     m_axis_tdata;

  // Predictor's copy of the viewport registers
  logic signed [COORD_BITS-1:0] view_left_q   = '0;
  logic signed [COORD_BITS-1:0] view_bottom_q = '0;
  logic signed [COORD_BITS-1:0] view_right_q  = '0;
  logic signed [COORD_BITS-1:0] view_top_q    = '0;

  cull_result_t pending_culls[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count;
  bit           send_idle_on = 1'b1;
  bit           recv_idle_on = 1'b1;

  segment_viewport_cull_unit #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Visibility, stroke and pen width of one segment against the current viewport
  function automatic cull_result_t predict_cull(segment_t seg);
    longint xi, yi, xf, yf, w, clr, margin;
    longint xl, xr, yb, yt, min_x, max_x, min_y, max_y, pen;
    longint corner_x [4];
    longint corner_y [4];
    logic signed [127:0] dx, dy, ox, oy, cross_prod;
    int above, below;
    cull_result_t res;
    xi = seg.start_x;
    yi = seg.start_y;
    xf = seg.end_x;
    yf = seg.end_y;
    w = seg.line_width;
    clr = seg.clearance;
    // truncating division, so -1/2 gives no margin
    margin = w / 2 + clr;
    xl = view_left_q - margin;
    xr = view_right_q + margin;
    yb = view_bottom_q - margin;
    yt = view_top_q + margin;
    min_x = (xi < xf) ? xi : xf;
    max_x = (xi < xf) ? xf : xi;
    min_y = (yi < yf) ? yi : yf;
    max_y = (yi < yf) ? yf : yi;
    res.visible = (max_x >= xl) && (min_x <= xr) && (max_y >= yb) && (min_y <= yt);
    // oblique: all four corners strictly on one side of the line means a miss
    if (res.visible && xi != xf && yi != yf) begin
      corner_x = '{xl, xr, xl, xr};
      corner_y = '{yb, yb, yt, yt};
      dx = xf - xi;
      dy = yf - yi;
      above = 0;
      below = 0;
      for (int k = 0; k < 4; k++) begin
        ox = corner_x[k] - xi;
        oy = corner_y[k] - yi;
        cross_prod = dx * oy - dy * ox;
        if (cross_prod > 0) above++;
        else if (cross_prod < 0) below++;
      end
      if (above == 4 || below == 4) res.visible = 1'b0;
    end
    pen = seg.draw_mode ? w : w + 2 * clr;
    res.pen_width = pen[PEN_W-1:0];
    res.stroke = res.visible && !(seg.draw_mode && w < 0);
    return res;
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom());
    return v;
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom(), $urandom()};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // Present one segment word, wait for acceptance, record its expected result
  task automatic send_segment(longint sx, longint sy, longint ex, longint ey,
                              longint w, longint clr, bit draw);
    segment_t seg;
    int unsigned gap;
    seg.start_x    = sx[COORD_BITS-1:0];
    seg.start_y    = sy[COORD_BITS-1:0];
    seg.end_x      = ex[COORD_BITS-1:0];
    seg.end_y      = ey[COORD_BITS-1:0];
    seg.line_width = w[COORD_BITS-1:0];
    seg.clearance  = clr[CLR_BITS-1:0];
    seg.draw_mode  = draw;
    gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'({seg.clearance, seg.line_width, seg.end_y, seg.end_x,
                               seg.start_y, seg.start_x});
    s_axis_tuser  <= seg.draw_mode;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_culls.push_back(predict_cull(seg));
  endtask

  // Stop sending and let every outstanding word come out
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_culls.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_view_reg(logic [svc_pkg::CFG_ADDR_BITS-1:0] idx, longint val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[COORD_BITS-1:0];
    @(posedge clk_i);
    case (idx)
      svc_pkg::REG_VIEW_LEFT:   view_left_q   = val[COORD_BITS-1:0];
      svc_pkg::REG_VIEW_BOTTOM: view_bottom_q = val[COORD_BITS-1:0];
      svc_pkg::REG_VIEW_RIGHT:  view_right_q  = val[COORD_BITS-1:0];
      default:                  view_top_q    = val[COORD_BITS-1:0];
    endcase
  endtask

  // Reprogram the viewport once the unit is empty
  task automatic set_viewport(longint left, longint bottom, longint right, longint top);
    drain_pipeline();
    write_view_reg(svc_pkg::REG_VIEW_LEFT, left);
    write_view_reg(svc_pkg::REG_VIEW_BOTTOM, bottom);
    write_view_reg(svc_pkg::REG_VIEW_RIGHT, right);
    write_view_reg(svc_pkg::REG_VIEW_TOP, top);
    cfg_we_i <= 1'b0;
  endtask

  // Zero viewport straight out of reset: margin sign and truncation
  task automatic test_reset_viewport();
    send_segment(0, 0, 0, 0, 0, 0, 1'b1);
    send_segment(1, 0, 1, 0, 0, 0, 1'b1);
    send_segment(1, 0, 1, 0, 2, 0, 1'b1);
    send_segment(0, 0, 0, 0, -1, 0, 1'b1);   // negative width, no stroke
    send_segment(0, 0, 0, 0, -3, 0, 1'b1);   // shrunk past inversion
    send_segment(0, 0, 0, 0, -5, 10, 1'b0);  // clearance outline pen
  endtask

  // Axis-aligned, oblique, corner touch and corner miss; inverted viewport
  task automatic test_line_geometry();
    set_viewport(-100, -50, 100, 50);
    send_segment(-1000, 0, 1000, 0, 4, 0, 1'b1);
    send_segment(200, -1000, 200, 1000, 0, 0, 1'b1);
    send_segment(200, -1000, 200, 1000, 0, 100, 1'b0);
    send_segment(-200, -200, 200, 200, 2, 1, 1'b1);
    send_segment(150, 0, 0, 150, 0, 0, 1'b1);   // line through top right corner
    send_segment(151, 0, 0, 151, 0, 0, 1'b1);   // just past it
    send_segment(0, 151, 151, 0, 1, 0, 1'b1);
    send_segment(-300, -300, -250, -250, 0, 0, 1'b1);
    set_viewport(100, 0, -100, 0);
    send_segment(-1000, 0, 1000, 0, 0, 0, 1'b1);
    send_segment(0, 0, 0, 0, 0, 0, 1'b1);
  endtask

  // Field and register extremes
  task automatic test_field_extremes();
    set_viewport(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, CLR_MAX, 1'b0);
    send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0, 1'b1);
    send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, CLR_MAX, 1'b0);
    send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, CLR_MAX, 1'b1);
    send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, -1, 0, 1'b0);
    set_viewport(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 1'b1);
    set_viewport(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, CLR_MAX, 1'b1);
  endtask

  // Random viewports, mostly segments around the viewport
  task automatic test_random_segments();
    longint ctr_x, ctr_y, half_w, half_h;
    longint lo_x, hi_x, lo_y, hi_y;
    longint sx, sy, ex, ey, w, clr;
    int unsigned kind;
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      send_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      recv_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      ctr_x  = rand_coord();
      ctr_y  = rand_coord();
      half_w = $urandom_range(0, 5000);
      half_h = $urandom_range(0, 5000);
      case ((phase == 0) ? 0 : $urandom_range(0, 4))
        0: set_viewport(ctr_x - half_w, ctr_y - half_h, ctr_x + half_w, ctr_y + half_h);
        1: set_viewport(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        2: set_viewport(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        3: set_viewport(ctr_x, ctr_y, ctr_x, ctr_y);
        default: set_viewport(ctr_x + half_w, ctr_y + half_h, ctr_x - half_w, ctr_y - half_h);
      endcase
      lo_x = ((view_left_q < view_right_q) ? view_left_q : view_right_q) - NEAR_PAD;
      hi_x = ((view_left_q < view_right_q) ? view_right_q : view_left_q) + NEAR_PAD;
      lo_y = ((view_bottom_q < view_top_q) ? view_bottom_q : view_top_q) - NEAR_PAD;
      hi_y = ((view_bottom_q < view_top_q) ? view_top_q : view_bottom_q) + NEAR_PAD;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6 || kind >= 8) begin
          sx = rand_between(lo_x, hi_x);
          sy = rand_between(lo_y, hi_y);
          ex = rand_between(lo_x, hi_x);
          ey = rand_between(lo_y, hi_y);
        end else begin
          sx = rand_coord();
          sy = rand_coord();
          ex = rand_coord();
          ey = rand_coord();
        end
        // axis-aligned and single point segments
        if (kind == 8) begin
          if ($urandom_range(0, 1) != 0) ex = sx;
          else ey = sy;
        end else if (kind == 9) begin
          ex = sx;
          ey = sy;
        end
        w   = ($urandom_range(0, 3) == 0) ? rand_coord() : rand_between(-3000, 3000);
        clr = ($urandom_range(0, 3) == 0) ? longint'($urandom() & CLR_MAX)
                                          : longint'($urandom_range(0, 1000));
        send_segment(sx, sy, ex, ey, w, clr, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side: random stall before each word
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    cull_result_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (pending_culls.size() == 0) begin
        $error("result word with no segment outstanding: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_culls.pop_front();
        if (m_axis_tdata[0] !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tdata[1] !== want.stroke) begin
          $error("stroke: expected %0d, got %0d", want.stroke, m_axis_tdata[1]);
          mismatch_count++;
        end
        if (m_axis_tdata[2+:PEN_W] !== want.pen_width) begin
          $error("pen_width: expected %0d, got %0d", $signed(want.pen_width),
                 $signed(m_axis_tdata[2+:PEN_W]));
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_viewport();
    test_line_geometry();
    test_field_extremes();
    test_random_segments();
    drain_pipeline();
    if (mismatch_count == 0 && pending_culls.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/svc_pkg.sv
hdl/segment_viewport_cull_unit.sv
tb/segment_viewport_cull_unit_tb.sv
